// ===== sv/rhc_pkg.sv =====
// Shared types, widths and the divider step function for the RGB to HSV converter.
package rhc_pkg;

  localparam int unsigned CHAN_W = 8;
  localparam int unsigned HUE_W  = 15;
  localparam int unsigned SAT_W  = 16;
  localparam int unsigned NUM_W  = 11;
  localparam int unsigned PROD_W = 17;
  localparam int unsigned INT_W  = 9;

  typedef struct packed {
    logic [CHAN_W-1:0] value;
    logic              grey;
    logic              black;
  } pix_t;

  typedef logic [CHAN_W:0] step_t;

  function automatic step_t div_step(input logic [CHAN_W-1:0] rem,
                                     input logic              bit_in,
                                     input logic [CHAN_W-1:0] dvsr);
    logic [CHAN_W:0]   wide;
    logic [CHAN_W:0]   diff;
    logic [CHAN_W-1:0] rem_out;
    logic              q;
    wide = {rem, bit_in};
    diff = wide - {1'b0, dvsr};
    if (wide >= {1'b0, dvsr}) begin
      q       = 1'b1;
      rem_out = diff[CHAN_W-1:0];
    end else begin
      q       = 1'b0;
      rem_out = wide[CHAN_W-1:0];
    end
    return {q, rem_out};
  endfunction

endpackage

// ===== sv/rhc_front.sv =====
// Input stage: finds max, min and delta and loads both divider lanes.
module rhc_front import rhc_pkg::*; #(
  parameter int unsigned HUE_FRAC_BITS = 6,
  parameter int unsigned SAT_FRAC_BITS = 15,
  parameter int unsigned HSW = INT_W + HUE_FRAC_BITS,
  parameter int unsigned SSW = SAT_FRAC_BITS + 1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_vld,
  input  logic [CHAN_W-1:0] red,
  input  logic [CHAN_W-1:0] green,
  input  logic [CHAN_W-1:0] blue,
  output logic              vld_r,
  output pix_t              pix_r,
  output logic [CHAN_W-1:0] h_rem_r,
  output logic [CHAN_W-1:0] h_div_r,
  output logic [HSW-1:0]    h_sh_r,
  output logic [CHAN_W-1:0] s_rem_r,
  output logic [CHAN_W-1:0] s_div_r,
  output logic [SSW-1:0]    s_sh_r
);

  logic [CHAN_W-1:0] mx;
  logic [CHAN_W-1:0] mn;
  logic [CHAN_W-1:0] delta;
  logic [NUM_W-1:0]  d_ext;
  logic [NUM_W-1:0]  num;
  logic [PROD_W-1:0] prod;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    delta = mx - mn;
    d_ext = NUM_W'(delta);
    if (mx == red) begin
      if (green >= blue) begin
        num = NUM_W'(green) - NUM_W'(blue);
      end else begin
        num = (d_ext << 2) + (d_ext << 1) - (NUM_W'(blue) - NUM_W'(green));
      end
    end else if (mx == green) begin
      num = (d_ext << 1) + NUM_W'(blue) - NUM_W'(red);
    end else begin
      num = (d_ext << 2) + NUM_W'(red) - NUM_W'(green);
    end
    prod = (PROD_W'(num) << 6) - (PROD_W'(num) << 2);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= in_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_r.value <= mx;
      pix_r.grey  <= (delta == '0);
      pix_r.black <= (mx == '0);
      h_rem_r     <= prod[PROD_W-1:INT_W];
      h_div_r     <= delta;
      h_sh_r      <= HSW'(prod[INT_W-1:0]) << HUE_FRAC_BITS;
      s_rem_r     <= {1'b0, delta[CHAN_W-1:1]};
      s_div_r     <= mx;
      s_sh_r      <= SSW'(delta[0]) << SAT_FRAC_BITS;
    end
  end

endmodule

// ===== sv/rhc_div_cell.sv =====
// One divider cell: a restoring step for the hue and saturation lanes, if enabled.
module rhc_div_cell import rhc_pkg::*; #(
  parameter int unsigned HQW  = 15,
  parameter int unsigned HSW  = 15,
  parameter bit          HACT = 1'b1,
  parameter int unsigned SQW  = 16,
  parameter int unsigned SSW  = 16,
  parameter bit          SACT = 1'b1
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              vld_i,
  input  pix_t              pix_i,
  input  logic [CHAN_W-1:0] h_rem_i,
  input  logic [CHAN_W-1:0] h_div_i,
  input  logic [HSW-1:0]    h_sh_i,
  input  logic [HQW-1:0]    h_q_i,
  input  logic [CHAN_W-1:0] s_rem_i,
  input  logic [CHAN_W-1:0] s_div_i,
  input  logic [SSW-1:0]    s_sh_i,
  input  logic [SQW-1:0]    s_q_i,
  output logic              vld_r,
  output pix_t              pix_r,
  output logic [CHAN_W-1:0] h_rem_r,
  output logic [CHAN_W-1:0] h_div_r,
  output logic [HSW-1:0]    h_sh_r,
  output logic [HQW-1:0]    h_q_r,
  output logic [CHAN_W-1:0] s_rem_r,
  output logic [CHAN_W-1:0] s_div_r,
  output logic [SSW-1:0]    s_sh_r,
  output logic [SQW-1:0]    s_q_r
);

  step_t            h_step;
  step_t            s_step;
  logic [CHAN_W-1:0] h_rem_nxt;
  logic [HSW-1:0]    h_sh_nxt;
  logic [HQW-1:0]    h_q_nxt;
  logic [CHAN_W-1:0] s_rem_nxt;
  logic [SSW-1:0]    s_sh_nxt;
  logic [SQW-1:0]    s_q_nxt;

  always_comb begin
    h_step = div_step(h_rem_i, h_sh_i[HSW-1], h_div_i);
    s_step = div_step(s_rem_i, s_sh_i[SSW-1], s_div_i);
    if (HACT) begin
      h_rem_nxt = h_step[CHAN_W-1:0];
      h_sh_nxt  = h_sh_i << 1;
      h_q_nxt   = {h_q_i[HQW-2:0], h_step[CHAN_W]};
    end else begin
      h_rem_nxt = h_rem_i;
      h_sh_nxt  = h_sh_i;
      h_q_nxt   = h_q_i;
    end
    if (SACT) begin
      s_rem_nxt = s_step[CHAN_W-1:0];
      s_sh_nxt  = s_sh_i << 1;
      s_q_nxt   = {s_q_i[SQW-2:0], s_step[CHAN_W]};
    end else begin
      s_rem_nxt = s_rem_i;
      s_sh_nxt  = s_sh_i;
      s_q_nxt   = s_q_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (adv) begin
      vld_r <= vld_i;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pix_r   <= pix_i;
      h_rem_r <= h_rem_nxt;
      h_div_r <= h_div_i;
      h_sh_r  <= h_sh_nxt;
      h_q_r   <= h_q_nxt;
      s_rem_r <= s_rem_nxt;
      s_div_r <= s_div_i;
      s_sh_r  <= s_sh_nxt;
      s_q_r   <= s_q_nxt;
    end
  end

endmodule

// ===== sv/rgb_to_hsv_converter_core.sv =====
// Top level of the pipelined RGB to HSV converter built from a row of divider cells.
//
// The input channel takes one 8-bit RGB pixel per transfer on in_red, in_green and
// in_blue; the output channel returns hue (degrees with HUE_FRAC_BITS fraction bits),
// saturation (Q with SAT_FRAC_BITS fraction bits) and value (largest channel).
// Both channels use valid and stall; a transfer happens when valid is high and stall
// is low.
// A front stage finds max, min and delta; then a row of max(9 + HUE_FRAC_BITS,
// SAT_FRAC_BITS + 1) cells each resolves one quotient bit of the hue and of the
// saturation division while that quotient still lacks bits. A pixel passes the front
// register and then each cell register in turn. A new pixel is taken every cycle
// unless in_stall is high, and the rate is one pixel per cycle while not stalled.
// When the receiver stalls while a result waits, the whole row holds and in_stall
// is raised; bubbles advance freely when the output register is empty.
// Reset clears the valid bits of every stage; no result is presented after reset
// until a pixel has passed through the row.
module rgb_to_hsv_converter_core import rhc_pkg::*; #(
  parameter int unsigned HUE_FRAC_BITS = 6,
  parameter int unsigned SAT_FRAC_BITS = 15
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [CHAN_W-1:0] in_red,
  input  logic [CHAN_W-1:0] in_green,
  input  logic [CHAN_W-1:0] in_blue,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [HUE_W-1:0]  out_hue,
  output logic [SAT_W-1:0]  out_saturation,
  output logic [CHAN_W-1:0] out_value
);

  localparam int unsigned HSW    = INT_W + HUE_FRAC_BITS;
  localparam int unsigned SSW    = SAT_FRAC_BITS + 1;
  localparam int unsigned HQW    = HSW;
  localparam int unsigned SQW    = SSW;
  localparam int unsigned NCELLS = (HSW > SSW) ? HSW : SSW;

  logic              adv;
  logic              vld   [0:NCELLS];
  pix_t              pix   [0:NCELLS];
  logic [CHAN_W-1:0] h_rem [0:NCELLS];
  logic [CHAN_W-1:0] h_div [0:NCELLS];
  logic [HSW-1:0]    h_sh  [0:NCELLS];
  logic [HQW-1:0]    h_q   [0:NCELLS];
  logic [CHAN_W-1:0] s_rem [0:NCELLS];
  logic [CHAN_W-1:0] s_div [0:NCELLS];
  logic [SSW-1:0]    s_sh  [0:NCELLS];
  logic [SQW-1:0]    s_q   [0:NCELLS];
  logic [HUE_W-1:0]  hue_raw;
  logic [SAT_W-1:0]  sat_raw;

  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  rhc_front #(
    .HUE_FRAC_BITS (HUE_FRAC_BITS),
    .SAT_FRAC_BITS (SAT_FRAC_BITS),
    .HSW           (HSW),
    .SSW           (SSW)
  ) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .in_vld  (in_valid),
    .red     (in_red),
    .green   (in_green),
    .blue    (in_blue),
    .vld_r   (vld[0]),
    .pix_r   (pix[0]),
    .h_rem_r (h_rem[0]),
    .h_div_r (h_div[0]),
    .h_sh_r  (h_sh[0]),
    .s_rem_r (s_rem[0]),
    .s_div_r (s_div[0]),
    .s_sh_r  (s_sh[0])
  );

  assign h_q[0] = '0;
  assign s_q[0] = '0;

  for (genvar i = 0; i < NCELLS; i++) begin : g_cell
    rhc_div_cell #(
      .HQW  (HQW),
      .HSW  (HSW),
      .HACT (i < HSW),
      .SQW  (SQW),
      .SSW  (SSW),
      .SACT (i < SSW)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .adv     (adv),
      .vld_i   (vld[i]),
      .pix_i   (pix[i]),
      .h_rem_i (h_rem[i]),
      .h_div_i (h_div[i]),
      .h_sh_i  (h_sh[i]),
      .h_q_i   (h_q[i]),
      .s_rem_i (s_rem[i]),
      .s_div_i (s_div[i]),
      .s_sh_i  (s_sh[i]),
      .s_q_i   (s_q[i]),
      .vld_r   (vld[i+1]),
      .pix_r   (pix[i+1]),
      .h_rem_r (h_rem[i+1]),
      .h_div_r (h_div[i+1]),
      .h_sh_r  (h_sh[i+1]),
      .h_q_r   (h_q[i+1]),
      .s_rem_r (s_rem[i+1]),
      .s_div_r (s_div[i+1]),
      .s_sh_r  (s_sh[i+1]),
      .s_q_r   (s_q[i+1])
    );
  end

  if (HQW >= HUE_W) begin : g_hue_trunc
    assign hue_raw = h_q[NCELLS][HUE_W-1:0];
  end else begin : g_hue_ext
    assign hue_raw = HUE_W'(h_q[NCELLS]);
  end

  if (SQW >= SAT_W) begin : g_sat_trunc
    assign sat_raw = s_q[NCELLS][SAT_W-1:0];
  end else begin : g_sat_ext
    assign sat_raw = SAT_W'(s_q[NCELLS]);
  end

  assign out_valid      = vld[NCELLS];
  assign out_hue        = pix[NCELLS].grey ? '0 : hue_raw;
  assign out_saturation = pix[NCELLS].black ? '0 : sat_raw;
  assign out_value      = pix[NCELLS].value;

endmodule
